[rtl/core/ioli_pkg.sv]
package ioli_pkg;

    localparam int MAX_IDS    = 1024;
    localparam int SLOT_COUNT = MAX_IDS + 1;
    localparam int ID_W       = $clog2(MAX_IDS);
    localparam int LINK_W     = $clog2(SLOT_COUNT);
    localparam int CMD_W      = 2;

    localparam logic [LINK_W-1:0] SENTINEL = LINK_W'(MAX_IDS);

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR2,
        ST_RD1,
        ST_RD2
    } t_state;

endpackage

[rtl/core/ioli_if.sv]
interface ioli_in_if import ioli_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  new_id;
    logic [ID_W-1:0]  anchor_id;
    logic             to_right;

    modport source (output valid, command, new_id, anchor_id, to_right, input ready);
    modport sink   (input valid, command, new_id, anchor_id, to_right, output ready);
endinterface

interface ioli_out_if import ioli_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] item_id;
    logic            last;

    modport source (output valid, item_id, last, input ready);
    modport sink   (input valid, item_id, last, output ready);
endinterface

[rtl/core/indexed_ordered_list_insert.sv]
// Channel   Direction  Handshake        Payload
// i_in      sink       valid / ready    command, new_id, anchor_id, to_right
// o_out     source     valid / ready    item_id, last
//
// Start and insert write both link memories in two steps, at the accept and in ST_WR2,
// as each memory has one write port; a read makes dependent lookups in the next-link
// memory, whose read is registered, and skips the second lookup when the list is empty.
// Reset is synchronous and clears the control state, the output valid flag and the read
// cursor only; the link memories hold nothing defined until written and have no clearing pass.
// A finished read waits in its last state while the output register is full and not taken.
module indexed_ordered_list_insert import ioli_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ioli_in_if.sink    i_in,
    ioli_out_if.source o_out
);

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_cursor, n_cursor;
    logic [ID_W-1:0]   r_new, n_new;
    logic [ID_W-1:0]   r_anchor, n_anchor;
    logic              r_right, n_right;
    logic              r_start, n_start;
    logic [ID_W-1:0]   r_pos, n_pos;
    logic              r_out_vld;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              emit;
    logic [ID_W-1:0]   emit_id;
    logic              emit_last;

    logic              nx_we, pv_we;
    logic [LINK_W-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata;
    logic [LINK_W-1:0] nx_raddr, pv_raddr, nx_rdata, pv_rdata;

    ioli_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    ioli_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cursor  <= SENTINEL;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_anchor <= n_anchor;
        r_right  <= n_right;
        r_start  <= n_start;
        r_pos    <= n_pos;
        if (emit) begin
            r_out_id   <= emit_id;
            r_out_last <= emit_last;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_new     = r_new;
        n_anchor  = r_anchor;
        n_right   = r_right;
        n_start   = r_start;
        n_pos     = r_pos;
        emit      = 1'b0;
        emit_id   = '0;
        emit_last = 1'b0;
        nx_we     = 1'b0;
        nx_waddr  = '0;
        nx_wdata  = '0;
        pv_we     = 1'b0;
        pv_waddr  = '0;
        pv_wdata  = '0;
        nx_raddr  = r_cursor;
        pv_raddr  = {1'b0, r_anchor};

        case (r_state)
            ST_IDLE: begin
                pv_raddr = {1'b0, i_in.anchor_id};
                nx_raddr = (t_cmd'(i_in.command) == CMD_READ) ? r_cursor
                                                              : {1'b0, i_in.anchor_id};
                if (in_acc) begin
                    n_new    = i_in.new_id;
                    n_anchor = i_in.anchor_id;
                    n_right  = i_in.to_right;
                    case (t_cmd'(i_in.command))
                        CMD_START: begin
                            n_start  = 1'b1;
                            nx_we    = 1'b1;
                            nx_waddr = SENTINEL;
                            nx_wdata = {1'b0, i_in.new_id};
                            pv_we    = 1'b1;
                            pv_waddr = SENTINEL;
                            pv_wdata = {1'b0, i_in.new_id};
                            n_cursor = SENTINEL;
                            n_state  = ST_WR2;
                        end
                        CMD_INSERT: begin
                            // The writes that do not need the neighbour go out now,
                            // in the same cycle as the neighbour lookup.
                            n_start = 1'b0;
                            nx_we   = 1'b1;
                            pv_we   = 1'b1;
                            if (i_in.to_right) begin
                                nx_waddr = {1'b0, i_in.anchor_id};
                                nx_wdata = {1'b0, i_in.new_id};
                                pv_waddr = {1'b0, i_in.new_id};
                                pv_wdata = {1'b0, i_in.anchor_id};
                            end else begin
                                pv_waddr = {1'b0, i_in.anchor_id};
                                pv_wdata = {1'b0, i_in.new_id};
                                nx_waddr = {1'b0, i_in.new_id};
                                nx_wdata = {1'b0, i_in.anchor_id};
                            end
                            n_state = ST_WR2;
                        end
                        CMD_READ: begin
                            n_state = ST_RD1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WR2: begin
                nx_we   = 1'b1;
                pv_we   = 1'b1;
                n_state = ST_IDLE;
                if (r_start) begin
                    nx_waddr = {1'b0, r_new};
                    nx_wdata = SENTINEL;
                    pv_waddr = {1'b0, r_new};
                    pv_wdata = SENTINEL;
                end else if (r_right) begin
                    nx_waddr = {1'b0, r_new};
                    nx_wdata = nx_rdata;
                    pv_waddr = nx_rdata;
                    pv_wdata = {1'b0, r_new};
                end else begin
                    // For a left insert the early writes were the later ones in order,
                    // so a late write that lands on the same entry must be dropped.
                    nx_we    = (pv_rdata != {1'b0, r_new});
                    nx_waddr = pv_rdata;
                    nx_wdata = {1'b0, r_new};
                    pv_we    = (r_new != r_anchor);
                    pv_waddr = {1'b0, r_new};
                    pv_wdata = pv_rdata;
                end
            end

            ST_RD1: begin
                if (nx_rdata >= SENTINEL) begin
                    nx_raddr = r_cursor;
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_id   = '0;
                        emit_last = 1'b1;
                        n_cursor  = SENTINEL;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    nx_raddr = nx_rdata;
                    n_pos    = nx_rdata[ID_W-1:0];
                    n_state  = ST_RD2;
                end
            end

            ST_RD2: begin
                nx_raddr = {1'b0, r_pos};
                if (out_free) begin
                    emit      = 1'b1;
                    emit_id   = r_pos;
                    emit_last = (nx_rdata == SENTINEL);
                    n_cursor  = (nx_rdata == SENTINEL) ? SENTINEL : {1'b0, r_pos};
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.item_id = r_out_id;
    assign o_out.last    = r_out_last;

    a_update_takes_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (t_cmd'(i_in.command) == CMD_START || t_cmd'(i_in.command) == CMD_INSERT))
        |=> (r_state == ST_WR2) ##1 (r_state == ST_IDLE))
        else $error("start or insert did not finish in two cycles");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= SENTINEL)
        else $error("read cursor beyond the sentinel slot");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_RD1 || r_state == ST_RD2))
        else $error("result produced outside a read");

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_cursor == SENTINEL))
        else $error("cursor not rewound after the final id");

endmodule

[rtl/core/ioli_ram.sv]
module ioli_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
